// ===== hdl/tls_pkg.sv =====
package tls_pkg;

  // default build values
  localparam int ANGLE_BITS_DEF = 16;
  localparam int SINE_FRAC_DEF  = 15;
  localparam int QUEUE_DEPTH    = 4;

  // command bytes
  localparam logic [7:0] SYM_FORWARD  = 8'h46;  // 'F'
  localparam logic [7:0] SYM_TURN_POS = 8'h2B;  // '+'
  localparam logic [7:0] SYM_TURN_NEG = 8'h2D;  // '-'

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y     = 2'd3;

  // configuration reset values
  localparam logic [15:0]        STEP_LENGTH_RST = 16'd5120;   // 20.0 in q8.8
  localparam logic [15:0]        TURN_ANGLE_RST  = 16'd10923;  // 60 degrees
  localparam logic signed [15:0] START_X_RST     = 16'sd250;
  localparam logic signed [15:0] START_Y_RST     = 16'sd400;

  // series arithmetic, q2.30
  localparam int Q_W   = 32;
  localparam int SUM_W = 34;
  localparam int TERMS = 9;
  localparam logic [30:0]          HALF_PI_Q30 = 31'h6487ED51;
  localparam logic [Q_W-1:0]       ONE_Q30     = 32'h4000_0000;
  localparam logic signed [SUM_W-1:0] ONE_Q30_S = 34'sh0_4000_0000;

  typedef struct packed {
    logic is_f;
    logic restart;
  } ctl_t;

  typedef struct packed {
    logic [15:0]        step_length;
    logic [15:0]        turn_angle;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } cfg_t;

  // one slot of the series pipeline
  typedef struct packed {
    ctl_t                    ctl;
    logic [1:0]              quad;
    logic [Q_W-1:0]          x2;
    logic [Q_W-1:0]          ts;
    logic [Q_W-1:0]          tc;
    logic signed [SUM_W-1:0] ss;
    logic signed [SUM_W-1:0] cc;
  } term_t;

endpackage

// ===== hdl/tls_front.sv =====
module tls_front #(
  parameter int ANGLE_BITS = tls_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_symbol,
  input  logic                  in_restart,
  input  logic [15:0]           turn_angle,
  input  logic                  q_full,
  output logic                  q_push,
  output tls_pkg::ctl_t         q_ctl,
  output logic [ANGLE_BITS-1:0] q_heading
);
  import tls_pkg::*;

  logic                  accept;
  logic                  is_f;
  logic                  is_pos;
  logic                  is_neg;
  logic [ANGLE_BITS-1:0] heading_r;
  logic [ANGLE_BITS-1:0] heading_nxt;
  logic [ANGLE_BITS-1:0] base;
  logic [ANGLE_BITS-1:0] turn;

  // classify the symbol
  assign accept = in_push & ~q_full;
  assign in_full = q_full;
  assign is_f   = (in_symbol == SYM_FORWARD);
  assign is_pos = (in_symbol == SYM_TURN_POS);
  assign is_neg = (in_symbol == SYM_TURN_NEG);

  // heading seen by this symbol, after a restart
  assign base = in_restart ? '0 : heading_r;
  assign turn = ANGLE_BITS'(turn_angle);

  always_comb begin
    heading_nxt = heading_r;
    if (accept) begin
      if (is_pos) begin
        heading_nxt = base + turn;
      end else if (is_neg) begin
        heading_nxt = base - turn;
      end else begin
        heading_nxt = base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
    end else begin
      heading_r <= heading_nxt;
    end
  end

  // moves and pen restarts go on to the back end
  assign q_push     = accept & (is_f | in_restart);
  assign q_ctl      = '{is_f: is_f, restart: in_restart};
  assign q_heading  = base;

endmodule

// ===== hdl/tls_queue.sv =====
module tls_queue #(
  parameter int W     = 18,
  parameter int DEPTH = tls_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         valid
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign do_push = push & ~full;
  assign do_pop  = pop & valid;
  assign full    = (count_r == (AW+1)'(DEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!do_push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/tls_term.sv =====
module tls_term #(
  parameter int DIV_S    = 6,
  parameter int DIV_C    = 2,
  parameter bit NEG_PREV = 1'b0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tls_pkg::term_t in_term,
  output logic           out_valid,
  output tls_pkg::term_t out_term
);
  import tls_pkg::*;

  localparam logic [Q_W-1:0] DS = Q_W'(DIV_S);
  localparam logic [Q_W-1:0] DC = Q_W'(DIV_C);
  localparam logic [Q_W-1:0] MS = Q_W'((64'd1 << 32) / DIV_S);
  localparam logic [Q_W-1:0] MC = Q_W'((64'd1 << 32) / DIV_C);

  logic           m_valid_r;
  logic           r_valid_r;
  logic           c_valid_r;
  term_t          m_r;
  term_t          r_r;
  term_t          c_r;
  term_t          m_nxt;
  term_t          c_nxt;
  logic [63:0]    ps_prod;
  logic [63:0]    pc_prod;
  logic [63:0]    qs_prod;
  logic [63:0]    qc_prod;
  logic [Q_W-1:0] qs0_r;
  logic [Q_W-1:0] qc0_r;
  logic [Q_W-1:0] rem_s;
  logic [Q_W-1:0] rem_c;
  logic signed [SUM_W-1:0] ts_ext;
  logic signed [SUM_W-1:0] tc_ext;

  // product with x squared, and fold the previous term into the sums
  assign ps_prod = 64'(in_term.ts) * 64'(in_term.x2);
  assign pc_prod = 64'(in_term.tc) * 64'(in_term.x2);
  assign ts_ext  = $signed({2'b00, in_term.ts});
  assign tc_ext  = $signed({2'b00, in_term.tc});

  always_comb begin
    m_nxt    = in_term;
    m_nxt.ts = ps_prod[61:30];
    m_nxt.tc = pc_prod[61:30];
    if (NEG_PREV) begin
      m_nxt.ss = in_term.ss - ts_ext;
      m_nxt.cc = in_term.cc - tc_ext;
    end else begin
      m_nxt.ss = in_term.ss + ts_ext;
      m_nxt.cc = in_term.cc + tc_ext;
    end
  end

  // quotient estimate by reciprocal, low by at most one
  assign qs_prod = 64'(m_r.ts) * 64'(MS);
  assign qc_prod = 64'(m_r.tc) * 64'(MC);

  // one correction step
  assign rem_s = r_r.ts - qs0_r * DS;
  assign rem_c = r_r.tc - qc0_r * DC;

  always_comb begin
    c_nxt    = r_r;
    c_nxt.ts = qs0_r + Q_W'(rem_s >= DS);
    c_nxt.tc = qc0_r + Q_W'(rem_c >= DC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= in_valid;
      r_valid_r <= m_valid_r;
      c_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r   <= m_nxt;
      r_r   <= m_r;
      qs0_r <= qs_prod[63:32];
      qc0_r <= qc_prod[63:32];
      c_r   <= c_nxt;
    end
  end

  assign out_valid = c_valid_r;
  assign out_term  = c_r;

endmodule

// ===== hdl/tls_back.sv =====
module tls_back #(
  parameter int ANGLE_BITS     = tls_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRAC_BITS = tls_pkg::SINE_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  tls_pkg::ctl_t         q_ctl,
  input  logic [ANGLE_BITS-1:0] q_heading,
  output logic                  q_pop,
  input  tls_pkg::cfg_t         cfg,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [15:0]    out_from_x,
  output logic signed [15:0]    out_from_y,
  output logic signed [15:0]    out_to_x,
  output logic signed [15:0]    out_to_y
);
  import tls_pkg::*;

  localparam int QS   = ANGLE_BITS - 2;
  localparam int XP_W = QS + 31;
  localparam int SF   = SINE_FRAC_BITS;
  localparam int PW   = SF + 17;
  localparam logic [31:0] HALF_ULP = 32'd1 << (29 - SF);
  localparam logic [31:0] ONE_FRAC = 32'd1 << SF;

  function automatic logic [SF:0] to_frac(input logic signed [SUM_W-1:0] v);
    logic [31:0] c;
    logic [31:0] r;
    if (v < 0) begin
      c = '0;
    end else if (v > ONE_Q30_S) begin
      c = ONE_Q30;
    end else begin
      c = v[31:0];
    end
    r = (c + HALF_ULP) >> (30 - SF);
    if (r > ONE_FRAC) begin
      r = ONE_FRAC;
    end
    return r[SF:0];
  endfunction

  logic en;

  // angle reduction
  logic              a_valid_r;
  ctl_t              a_ctl_r;
  logic [1:0]        a_quad_r;
  logic [30:0]       a_x_r;
  logic [XP_W-1:0]   x_prod;
  logic [61:0]       x2_prod;

  // series chain
  logic              b_valid_r;
  term_t             b_r;
  logic              chain_v [0:TERMS];
  term_t             chain [0:TERMS];

  // last term, then clamp and round
  logic              f1_valid_r;
  ctl_t              f1_ctl_r;
  logic [1:0]        f1_quad_r;
  logic signed [SUM_W-1:0] f1_ss_r;
  logic signed [SUM_W-1:0] f1_cc_r;
  logic              f2_valid_r;
  ctl_t              f2_ctl_r;
  logic [1:0]        f2_quad_r;
  logic [SF:0]       f2_sin_r;
  logic [SF:0]       f2_cos_r;

  // displacement
  logic              d1_valid_r;
  ctl_t              d1_ctl_r;
  logic              d1_xneg_r;
  logic              d1_yneg_r;
  logic [PW-1:0]     d1_xprod_r;
  logic [PW-1:0]     d1_yprod_r;
  logic [SF:0]       x_mag;
  logic [SF:0]       y_mag;
  logic              x_neg;
  logic              y_neg;

  // pen and result
  logic [15:0]       pen_x_r;
  logic [15:0]       pen_y_r;
  logic [15:0]       base_x;
  logic [15:0]       base_y;
  logic [15:0]       dx;
  logic [15:0]       dy;
  logic [15:0]       to_x;
  logic [15:0]       to_y;
  logic              out_valid_r;
  logic [15:0]       out_from_x_r;
  logic [15:0]       out_from_y_r;
  logic [15:0]       out_to_x_r;
  logic [15:0]       out_to_y_r;

  // whole pipeline moves unless a result waits untaken
  assign en    = ~out_valid_r | out_pop;
  assign q_pop = en & q_valid;

  // quadrant and remainder scaled to radians
  assign x_prod = XP_W'(q_heading[QS-1:0]) * XP_W'(HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl_r  <= q_ctl;
      a_quad_r <= q_heading[ANGLE_BITS-1:ANGLE_BITS-2];
      a_x_r    <= x_prod[XP_W-1:QS];
    end
  end

  // square of the angle seeds the series
  assign x2_prod = 62'(a_x_r) * 62'(a_x_r);

  always_ff @(posedge clk) begin
    if (en) begin
      b_r.ctl  <= a_ctl_r;
      b_r.quad <= a_quad_r;
      b_r.x2   <= x2_prod[61:30];
      b_r.ts   <= Q_W'(a_x_r);
      b_r.tc   <= ONE_Q30;
      b_r.ss   <= '0;
      b_r.cc   <= '0;
    end
  end

  assign chain_v[0] = b_valid_r;
  assign chain[0]   = b_r;

  for (genvar j = 1; j <= TERMS; j++) begin : g_term
    tls_term #(
      .DIV_S   ((2 * j) * (2 * j + 1)),
      .DIV_C   ((2 * j - 1) * (2 * j)),
      .NEG_PREV(bit'((j - 1) % 2))
    ) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (chain_v[j-1]),
      .in_term  (chain[j-1]),
      .out_valid(chain_v[j]),
      .out_term (chain[j])
    );
  end

  // tenth term has odd index and is subtracted
  always_ff @(posedge clk) begin
    if (en) begin
      f1_ctl_r  <= chain[TERMS].ctl;
      f1_quad_r <= chain[TERMS].quad;
      f1_ss_r   <= chain[TERMS].ss - $signed({2'b00, chain[TERMS].ts});
      f1_cc_r   <= chain[TERMS].cc - $signed({2'b00, chain[TERMS].tc});
      f2_ctl_r  <= f1_ctl_r;
      f2_quad_r <= f1_quad_r;
      f2_sin_r  <= to_frac(f1_ss_r);
      f2_cos_r  <= to_frac(f1_cc_r);
    end
  end

  // quadrant sign and swap
  always_comb begin
    unique case (f2_quad_r)
      2'd0: begin
        x_mag = f2_cos_r; x_neg = 1'b0; y_mag = f2_sin_r; y_neg = 1'b0;
      end
      2'd1: begin
        x_mag = f2_sin_r; x_neg = 1'b1; y_mag = f2_cos_r; y_neg = 1'b0;
      end
      2'd2: begin
        x_mag = f2_cos_r; x_neg = 1'b1; y_mag = f2_sin_r; y_neg = 1'b1;
      end
      default: begin
        x_mag = f2_sin_r; x_neg = 1'b0; y_mag = f2_cos_r; y_neg = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_ctl_r   <= f2_ctl_r;
      d1_xneg_r  <= x_neg;
      d1_yneg_r  <= y_neg;
      d1_xprod_r <= PW'(cfg.step_length) * PW'(x_mag);
      d1_yprod_r <= PW'(cfg.step_length) * PW'(y_mag);
    end
  end

  // valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      d1_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r  <= q_pop;
      b_valid_r  <= a_valid_r;
      f1_valid_r <= chain_v[TERMS];
      f2_valid_r <= f1_valid_r;
      d1_valid_r <= f2_valid_r;
    end
  end

  // truncated magnitude, sign applied, added with wraparound
  assign dx     = d1_xneg_r ? 16'd0 - 16'(d1_xprod_r[PW-1:SF+8])
                            : 16'(d1_xprod_r[PW-1:SF+8]);
  assign dy     = d1_yneg_r ? 16'd0 - 16'(d1_yprod_r[PW-1:SF+8])
                            : 16'(d1_yprod_r[PW-1:SF+8]);
  assign base_x = d1_ctl_r.restart ? cfg.start_x : pen_x_r;
  assign base_y = d1_ctl_r.restart ? cfg.start_y : pen_y_r;
  assign to_x   = base_x + dx;
  assign to_y   = base_y + dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pen_x_r     <= START_X_RST;
      pen_y_r     <= START_Y_RST;
    end else if (en) begin
      out_valid_r <= d1_valid_r & d1_ctl_r.is_f;
      if (d1_valid_r) begin
        pen_x_r <= d1_ctl_r.is_f ? to_x : base_x;
        pen_y_r <= d1_ctl_r.is_f ? to_y : base_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && d1_valid_r && d1_ctl_r.is_f) begin
      out_from_x_r <= base_x;
      out_from_y_r <= base_y;
      out_to_x_r   <= to_x;
      out_to_y_r   <= to_y;
    end
  end

  assign out_empty  = ~out_valid_r;
  assign out_from_x = $signed(out_from_x_r);
  assign out_from_y = $signed(out_from_y_r);
  assign out_to_x   = $signed(out_to_x_r);
  assign out_to_y   = $signed(out_to_y_r);

endmodule

// ===== hdl/turtle_line_stepper_top.sv =====
// channel   direction  handshake         payload
// in_       input      push / full       symbol[7:0], restart
// out_      output     pop / empty       from_x, from_y, to_x, to_y (signed 16)
// cfg_      input      we, index, wdata  step_length, turn_angle, start_x, start_y
//
// one symbol per cycle while the queue is not full; an 'F' shows its segment after it
// leaves the queue and passes the angle registers, nine series stages of three registers
// each, and the rounding, displacement and output registers
// synchronous reset zeroes heading and valid bits, loads pen and registers
// a result left on the ports freezes the back pipeline; the front keeps taking
// symbols until the queue fills, and symbols that only turn never enter it
module turtle_line_stepper_top #(
  parameter int ANGLE_BITS     = tls_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRAC_BITS = tls_pkg::SINE_FRAC_DEF,
  parameter int QUEUE_DEPTH    = tls_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_symbol,
  input  logic               in_restart,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_from_x,
  output logic signed [15:0] out_from_y,
  output logic signed [15:0] out_to_x,
  output logic signed [15:0] out_to_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import tls_pkg::*;

  localparam int QW = $bits(ctl_t) + ANGLE_BITS;

  cfg_t                  cfg_r;
  cfg_t                  cfg_nxt;
  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  ctl_t                  q_wctl;
  logic [ANGLE_BITS-1:0] q_wheading;
  logic [QW-1:0]         q_rdata;
  ctl_t                  q_rctl;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_LENGTH: cfg_nxt.step_length = cfg_wdata;
        REG_TURN_ANGLE:  cfg_nxt.turn_angle  = cfg_wdata;
        REG_START_X:     cfg_nxt.start_x     = $signed(cfg_wdata);
        REG_START_Y:     cfg_nxt.start_y     = $signed(cfg_wdata);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_length <= STEP_LENGTH_RST;
      cfg_r.turn_angle  <= TURN_ANGLE_RST;
      cfg_r.start_x     <= START_X_RST;
      cfg_r.start_y     <= START_Y_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // heading tracking and symbol classification
  tls_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_symbol (in_symbol),
    .in_restart(in_restart),
    .turn_angle(cfg_r.turn_angle),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (q_wctl),
    .q_heading (q_wheading)
  );

  // decoupling queue
  tls_queue #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata({q_wctl, q_wheading}),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .valid(q_valid)
  );

  assign q_rctl = ctl_t'(q_rdata[QW-1:ANGLE_BITS]);

  // trig, displacement and pen
  tls_back #(
    .ANGLE_BITS    (ANGLE_BITS),
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ctl     (q_rctl),
    .q_heading (q_rdata[ANGLE_BITS-1:0]),
    .q_pop     (q_pop),
    .cfg       (cfg_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_from_x(out_from_x),
    .out_from_y(out_from_y),
    .out_to_x  (out_to_x),
    .out_to_y  (out_to_y)
  );

`ifndef SYNTHESIS
  // back end only takes real queue entries
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // a waiting result that is not taken holds the whole back end
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |-> !q_pop)
    else $error("queue popped during output stall");

  // a result leaves only through a transfer
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_empty) |-> $past(out_pop))
    else $error("result dropped without transfer");
`endif

endmodule

// ===== tb/segment_checker.sv =====
`timescale 1ns / 100ps

// watches the symbol, segment and register channels, predicts every segment
// and compares each segment transfer against the oldest prediction
module segment_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [7:0]         in_symbol,
  input  logic               in_restart,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [15:0] out_from_x,
  input  logic signed [15:0] out_from_y,
  input  logic signed [15:0] out_to_x,
  input  logic signed [15:0] out_to_y,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import tls_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
  } segment_t;

  localparam u64_t UNIT_Q30 = u64_t'(1) << 30;
  localparam u64_t QUARTER_TURN_Q30 = 64'h6487ED51;
  localparam int   REPORT_MAX = 10;

  // shadow of the configuration and the pen
  logic [15:0] step_len;
  logic [15:0] turn_step;
  logic [15:0] home_x;
  logic [15:0] home_y;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [15:0] heading;

  segment_t expected_segments[$];

  function automatic u64_t q30_mul(u64_t a, u64_t b);
    return (a * b) >> 30;
  endfunction

  function automatic u64_t q30_clamp(longint v);
    if (v < 0) return 0;
    if (v > longint'(UNIT_Q30)) return UNIT_Q30;
    return u64_t'(v);
  endfunction

  // q30 magnitude rounded half up to q1.15, limited to 1.0
  function automatic longint q15_round(u64_t v);
    u64_t r;
    r = (v + (u64_t'(1) << 14)) >> 15;
    if (r > (u64_t'(1) << 15)) r = u64_t'(1) << 15;
    return longint'(r);
  endfunction

  // sine and cosine of a binary angle, series over the first quadrant
  function automatic void heading_trig(input logic [15:0] h, output longint sn,
                                       output longint cs);
    u64_t   x;
    u64_t   x2;
    u64_t   ts;
    u64_t   tc;
    longint ss;
    longint cc;
    longint fs;
    longint fc;
    int     k;
    x  = (u64_t'(h[13:0]) * QUARTER_TURN_Q30) >> 14;
    x2 = q30_mul(x, x);
    ts = x;
    tc = UNIT_Q30;
    ss = 0;
    cc = 0;
    for (k = 0; k < 10; k++) begin
      if (k % 2 == 1) begin
        ss = ss - longint'(ts);
        cc = cc - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cc = cc + longint'(tc);
      end
      ts = q30_mul(ts, x2) / u64_t'((2 * k + 2) * (2 * k + 3));
      tc = q30_mul(tc, x2) / u64_t'((2 * k + 1) * (2 * k + 2));
    end
    fs = q15_round(q30_clamp(ss));
    fc = q15_round(q30_clamp(cc));
    case (h[15:14])
      2'd0: begin sn = fs;  cs = fc;  end
      2'd1: begin sn = fc;  cs = -fs; end
      2'd2: begin sn = -fs; cs = -fc; end
      default: begin sn = -fc; cs = fs; end
    endcase
  endfunction

  // step times trig, truncated toward zero, added with 16-bit wrap
  function automatic logic [15:0] move_coord(logic [15:0] pos, longint trig,
                                             logic [15:0] len);
    longint p;
    u64_t   mag;
    u64_t   d;
    p   = longint'(len) * trig;
    mag = u64_t'((p < 0) ? -p : p) >> 23;
    d   = (p < 0) ? (u64_t'(0) - mag) : mag;
    return pos + d[15:0];
  endfunction

  always @(posedge clk) begin
    segment_t want;
    segment_t got;
    longint   sn;
    longint   cs;
    if (!rst_n) begin
      step_len   = STEP_LENGTH_RST;
      turn_step  = TURN_ANGLE_RST;
      home_x     = START_X_RST;
      home_y     = START_Y_RST;
      pen_x      = START_X_RST;
      pen_y      = START_Y_RST;
      heading    = '0;
      fail_count = 0;
      expected_segments.delete();
    end else begin
      // segment transfer
      if (out_pop && !out_empty) begin
        got = '{out_from_x, out_from_y, out_to_x, out_to_y};
        if (expected_segments.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected segment (%0d,%0d)->(%0d,%0d)",
                     got.from_x, got.from_y, got.to_x, got.to_y);
        end else begin
          want = expected_segments.pop_front();
          if (got.from_x !== want.from_x || got.from_y !== want.from_y ||
              got.to_x !== want.to_x || got.to_y !== want.to_y) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("segment mismatch: expected (%0d,%0d)->(%0d,%0d) got (%0d,%0d)->(%0d,%0d)",
                       want.from_x, want.from_y, want.to_x, want.to_y,
                       got.from_x, got.from_y, got.to_x, got.to_y);
          end
        end
      end
      // symbol transfer
      if (in_push && !in_full) begin
        if (in_restart) begin
          pen_x   = home_x;
          pen_y   = home_y;
          heading = '0;
        end
        case (in_symbol)
          SYM_TURN_POS: heading = heading + turn_step;
          SYM_TURN_NEG: heading = heading - turn_step;
          SYM_FORWARD: begin
            heading_trig(heading, sn, cs);
            want.from_x = pen_x;
            want.from_y = pen_y;
            want.to_x   = move_coord(pen_x, cs, step_len);
            want.to_y   = move_coord(pen_y, sn, step_len);
            expected_segments.push_back(want);
            pen_x = want.to_x;
            pen_y = want.to_y;
          end
          default: ;
        endcase
      end
      // register write
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_LENGTH: step_len  = cfg_wdata;
          REG_TURN_ANGLE:  turn_step = cfg_wdata;
          REG_START_X:     home_x    = cfg_wdata;
          default:         home_y    = cfg_wdata;
        endcase
      end
    end
    pending = expected_segments.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tls_pkg::*;

  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 235;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [7:0]         in_symbol;
  logic               in_restart;
  logic               out_empty;
  logic               out_pop;
  logic signed [15:0] out_from_x;
  logic signed [15:0] out_from_y;
  logic signed [15:0] out_to_x;
  logic signed [15:0] out_to_y;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  bit                 sender_steady;
  bit                 receiver_steady;

  turtle_line_stepper_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_symbol  (in_symbol),
    .in_restart (in_restart),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_from_x (out_from_x),
    .out_from_y (out_from_y),
    .out_to_x   (out_to_x),
    .out_to_y   (out_to_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  segment_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_symbol  (in_symbol),
    .in_restart (in_restart),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_from_x (out_from_x),
    .out_from_y (out_from_y),
    .out_to_x   (out_to_x),
    .out_to_y   (out_to_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("turtle_line_stepper_top test failed");
        $finish;
      end
    end
  end

  // segment receiver with random stalls
  initial begin
    int stall;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = receiver_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        @(negedge clk) out_pop <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  // one symbol transfer after a random gap
  task automatic send_symbol(logic [7:0] sym, logic rs);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk) in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_symbol  <= sym;
    in_restart <= rs;
    do @(posedge clk); while (in_full);
  endtask

  // stop sending and wait for every predicted segment
  task automatic drain_segments();
    @(negedge clk) in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // registers change only once the pipeline is empty
  task automatic load_config(logic [15:0] len, logic [15:0] turn, logic [15:0] sx,
                             logic [15:0] sy);
    drain_segments();
    repeat (HOLD_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_LENGTH;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_index <= REG_TURN_ANGLE;
    cfg_wdata <= turn;
    @(negedge clk);
    cfg_index <= REG_START_X;
    cfg_wdata <= sx;
    @(negedge clk);
    cfg_index <= REG_START_Y;
    cfg_wdata <= sy;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  initial begin
    int          r;
    logic [7:0]  sym;
    logic [15:0] len;
    logic [15:0] turn;
    in_push         = 1'b0;
    in_symbol       = '0;
    in_restart      = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_STEP_LENGTH;
    cfg_wdata       = '0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    rst_n           = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: each command, restarts, ignored bytes, heading wrap both ways
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_TURN_POS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_TURN_NEG, 1'b0);
    send_symbol(SYM_TURN_NEG, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_FORWARD, 1'b1);
    send_symbol(SYM_TURN_POS, 1'b1);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'h66, 1'b0);
    send_symbol(8'h2C, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    repeat (6) send_symbol(SYM_TURN_POS, 1'b0);
    send_symbol(SYM_FORWARD, 1'b0);
    send_symbol(SYM_TURN_NEG, 1'b1);
    send_symbol(SYM_FORWARD, 1'b0);

    // random phases, each under its own register setting
    for (int p = 1; p <= PHASES; p++) begin
      len  = 16'($urandom_range(0, 65535));
      turn = 16'($urandom_range(0, 65535));
      case (p)
        1: load_config(16'd0, 16'd0, 16'sh8000, 16'sh7FFF);
        2: load_config(16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000);
        3: load_config(16'd256, 16'd16384, 16'd0, 16'd0);
        4: load_config(len, 16'd8192, 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)));
        5: load_config(len, 16'd1, 16'sh8000, 16'sh8000);
        default: load_config(len, turn, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sender_steady   = (i >= 30 && i < 90);
        receiver_steady = (i >= 150 && i < 200);
        if (i == 120) drain_segments();
        r = $urandom_range(0, 99);
        if (r < 45) sym = SYM_FORWARD;
        else if (r < 65) sym = SYM_TURN_POS;
        else if (r < 85) sym = SYM_TURN_NEG;
        else sym = 8'($urandom_range(0, 255));
        send_symbol(sym, $urandom_range(0, 19) == 0);
      end
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;

    // let the last segments drain, then give the verdict
    drain_segments();
    repeat (HOLD_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("turtle_line_stepper_top test passed");
    end else begin
      $display("turtle_line_stepper_top test failed");
    end
    $finish;
  end

endmodule
